@@ rtl/core/spr_pkg.sv @@
package spr_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FLAT      = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd7;

    localparam int REL_SCALE = 1000;

    // request to the divider
    typedef struct packed {
        logic              start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic signed [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

@@ rtl/core/spr_div.sv @@
module spr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spr_pkg::t_div_req    i_req,
    output spr_pkg::t_div_rsp    o_rsp
);

    // restoring divider, one quotient bit a cycle, truncating toward zero
    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_trial;
    logic [63:0] w_num_abs;

    assign w_num_abs = i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
    assign w_trial   = {r_rem[63:0], r_quo[63]} - {33'd0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = w_num_abs;
            n_rem  = '0;
            n_den  = i_req.den[31] ? 32'(-i_req.den) : 32'(i_req.den);
            n_neg  = i_req.num[63] ^ i_req.den[31];
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[64]) begin
                n_rem = w_trial;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[63:0], r_quo[63]};
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

@@ rtl/core/secant_polynomial_root_finder_core.sv @@
// channel | valid            | stall            | payload
// input   | i_in_valid       | o_in_stall       | i_guess_first, i_guess_second
// output  | o_out_valid      | i_out_stall      | o_root_value, o_iterations_used, o_status
// config  | i_cfg_wr_en      | -                | i_cfg_index, i_cfg_data
//
// one iteration: two Horner evaluations (load the top coefficient, then a
// multiply and an add per degree), a compare, the product f2 * (x2 - x1),
// a wait on the bit-serial divider and a relative test; an item runs up to the
// iteration limit (0 acts as 1) in iterations; the divider wait takes most of it
// one item at a time: o_in_stall is high from accept until the result leaves
// reset (synchronous, active low) restores the register defaults and idles
// the sequencer; the result waits in the output register while stalled
module secant_polynomial_root_finder_core #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [31:0] i_guess_first,
    input  logic signed [31:0] i_guess_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_root_value,
    output logic [7:0]  o_iterations_used,
    output logic [1:0]  o_status
);

    localparam int COEF_N = 6;
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1) < 3 ? 3 : $clog2(MAX_DEGREE + 1);

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVINI = 4'd1;  // load top coefficient
    localparam logic [3:0] S_MUL   = 4'd2;  // acc * x, registered
    localparam logic [3:0] S_ADD   = 4'd3;  // acc + coef
    localparam logic [3:0] S_CHK   = 4'd4;  // compare f1, f2
    localparam logic [3:0] S_PROD  = 4'd5;  // f2 * d
    localparam logic [3:0] S_DIV   = 4'd6;  // wait divider
    localparam logic [3:0] S_TEST  = 4'd7;  // |x3-x2|*1000
    localparam logic [3:0] S_CMP   = 4'd8;  // relative test
    localparam logic [3:0] S_OUT   = 4'd9;

    // config registers
    logic signed [31:0] r_coef [COEF_N];
    logic [2:0] r_degree;
    logic [7:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= 32'sd0;
            r_coef[1] <= 32'sd1376256;
            r_coef[2] <= -32'sd1441792;
            r_coef[3] <= 32'sd65536;
            r_coef[4] <= 32'sd0;
            r_coef[5] <= 32'sd0;
            r_degree  <= 3'd3;
            r_limit   <= 8'd64;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == spr_pkg::REG_DEGREE) begin
                r_degree <= i_cfg_data[2:0];
            end else if (i_cfg_index == spr_pkg::REG_LIMIT) begin
                r_limit <= i_cfg_data[7:0];
            end else if (int'(i_cfg_index) < COEF_N) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // effective degree, saturated to MAX_DEGREE
    logic [DEG_W-1:0] w_deg;
    assign w_deg = (int'(r_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(r_degree);

    function automatic logic signed [31:0] coef_at(input logic [DEG_W-1:0] k,
                                                   input logic signed [31:0] c0,
                                                   input logic signed [31:0] c1,
                                                   input logic signed [31:0] c2,
                                                   input logic signed [31:0] c3,
                                                   input logic signed [31:0] c4,
                                                   input logic signed [31:0] c5);
        case (int'(k))
            0: coef_at = c0;
            1: coef_at = c1;
            2: coef_at = c2;
            3: coef_at = c3;
            4: coef_at = c4;
            5: coef_at = c5;
            default: coef_at = 32'sd0;
        endcase
    endfunction

    logic [3:0]         r_state;
    logic signed [31:0] r_x1, r_x2, r_x3, r_acc, r_f1;
    logic               r_which;        // 0 evaluating at x1, 1 at x2
    logic [DEG_W-1:0]   r_k;
    logic [7:0]         r_cnt, r_lim;
    logic signed [63:0] r_prod;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [65:0]        r_lhs;

    // shared multiplier operands
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mres;
    always_comb begin
        w_ma = r_acc;
        w_mb = r_which ? r_x2 : r_x1;
        if (r_state == S_PROD) begin
            w_ma = r_acc;  // f2
            w_mb = spr_pkg::sat32(66'(r_x2) - 66'(r_x1));
        end
    end
    assign w_mres = w_ma * w_mb;

    spr_pkg::t_div_req w_dreq;
    spr_pkg::t_div_rsp w_drsp;
    assign w_dreq.start = (r_state == S_PROD);
    assign w_dreq.num   = w_mres;
    assign w_dreq.den   = spr_pkg::sat32(66'(r_acc) - 66'(r_f1));

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    logic signed [31:0] w_mulq, w_coefk, w_x3;
    logic signed [65:0] w_step;
    logic [65:0]        w_abs_step;
    logic [31:0]        w_abs_x3;
    assign w_mulq  = spr_pkg::sat32(66'(r_prod >>> FRAC_BITS));
    assign w_coefk = coef_at(r_k, r_coef[0], r_coef[1], r_coef[2], r_coef[3],
                             r_coef[4], r_coef[5]);
    assign w_x3    = spr_pkg::sat32(66'(r_x2) - 66'(spr_pkg::sat32(66'(w_drsp.quo))));
    assign w_step  = 66'(r_x3) - 66'(r_x2);
    assign w_abs_step = w_step[65] ? 66'(-w_step) : 66'(w_step);
    assign w_abs_x3   = r_x3[31] ? 32'(-33'(r_x3)) : 32'(r_x3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x1    <= i_guess_first;
                        r_x2    <= i_guess_second;
                        r_x3    <= i_guess_second;
                        r_cnt   <= 8'd1;
                        r_lim   <= (r_limit == 8'd0) ? 8'd1 : r_limit;
                        r_which <= 1'b0;
                        r_state <= S_EVINI;
                    end
                end
                S_EVINI: begin
                    r_acc   <= coef_at(w_deg, r_coef[0], r_coef[1], r_coef[2],
                                       r_coef[3], r_coef[4], r_coef[5]);
                    r_k     <= w_deg;
                    r_state <= (w_deg == '0) ? S_CHK : S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_mres;
                    r_k     <= r_k - DEG_W'(1);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= spr_pkg::sat32(66'(w_mulq) + 66'(w_coefk));
                    if (r_k == '0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    if (!r_which) begin
                        r_f1    <= r_acc;
                        r_which <= 1'b1;
                        r_state <= S_EVINI;
                    end else if (r_acc == r_f1) begin
                        r_x3     <= r_x2;
                        r_status <= spr_pkg::ST_FLAT;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_x3    <= w_x3;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_lhs   <= 66'(w_abs_step[43:0] * 11'd1000);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_lhs < 66'(w_abs_x3)) begin
                        r_status <= spr_pkg::ST_CONVERGED;
                        r_state  <= S_OUT;
                    end else if (r_cnt == r_lim) begin
                        r_status <= spr_pkg::ST_LIMIT;
                        r_state  <= S_OUT;
                    end else begin
                        r_x1    <= r_x2;
                        r_x2    <= r_x3;
                        r_cnt   <= r_cnt + 8'd1;
                        r_which <= 1'b0;
                        r_state <= S_EVINI;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_root_value      = r_x3;
    assign o_iterations_used = r_cnt;
    assign o_status          = r_status;

`ifndef SYNTHESIS
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT) else $error("output valid outside result state");
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> r_cnt <= r_lim) else $error("iteration count past limit");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_status != 2'd3) else $error("bad status");
`endif

endmodule
